// ----- rtl/ils_pkg.sv -----
package ils_pkg;

    localparam int ILS_CAPACITY  = 256;
    localparam int ILS_WORD_BITS = 32;

    typedef enum logic [2:0] {
        REQ_GET    = 3'd0,
        REQ_SET    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_APPEND = 3'd3,
        REQ_REMOVE = 3'd4
    } t_req_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status_e;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [8:0]  index;
        logic [31:0] item;
    } t_in_req;

    typedef struct packed {
        logic [31:0] read_item;
        logic [8:0]  count_now;
        logic [1:0]  status;
    } t_out_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decide;
        logic rd_idx;
        logic wr_idx;
        logic shift_up;
        logic shift_dn;
        logic shift_step;
        logic finish;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] req;
        t_status_e  chk;
        logic       shift_busy;
        logic       out_free;
    } t_dp_sts;

endpackage

// ----- rtl/ils_ctrl.sv -----
module ils_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ils_pkg::t_dp_sts i_sts,
    output ils_pkg::t_dp_cmd o_cmd
);
    import ils_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_FINISH = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state_e;

    t_state_e r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_EMIT;
                if (i_sts.chk == ST_OK) begin
                    case (i_sts.req)
                        REQ_GET: o_cmd.rd_idx = 1'b1;
                        REQ_SET: o_cmd.wr_idx = 1'b1;
                        REQ_INSERT, REQ_APPEND: begin
                            o_cmd.shift_up = 1'b1;
                            n_state        = S_SHIFT;
                        end
                        REQ_REMOVE: begin
                            o_cmd.shift_dn = 1'b1;
                            n_state        = S_SHIFT;
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_busy) begin
                    o_cmd.shift_step = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/ils_datapath.sv -----
module ils_datapath #(
    parameter int CAPACITY  = ils_pkg::ILS_CAPACITY,
    parameter int WORD_BITS = ils_pkg::ILS_WORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ils_pkg::t_in_req  i_req,
    input  ils_pkg::t_dp_cmd  i_cmd,
    output ils_pkg::t_dp_sts  o_sts,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ils_pkg::t_out_rsp o_rsp
);
    import ils_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    logic [WORD_BITS-1:0] mem [CAPACITY];

    t_in_req              r_req;
    logic [CW-1:0]        r_count;
    t_status_e            r_st;
    logic [AW-1:0]        r_ptr;
    logic [AW-1:0]        r_wa;
    logic [CW-1:0]        r_left;
    logic                 r_up;
    logic                 r_pend;
    logic [WORD_BITS-1:0] r_rd_q;
    logic                 r_out_valid;
    t_out_rsp             r_rsp;

    logic [XW-1:0]        count_x;
    logic [XW-1:0]        pos_x;
    logic [AW-1:0]        pos_a;
    logic [63:0]          item_x;
    logic [63:0]          rd_x;
    t_status_e            chk;
    logic                 full;
    logic                 we;
    logic [AW-1:0]        wa;
    logic [WORD_BITS-1:0] wd;
    logic                 re;
    logic [AW-1:0]        ra;

    assign count_x = XW'(r_count);
    assign pos_x   = (r_req.req_type == REQ_APPEND) ? count_x : XW'(r_req.index);
    assign pos_a   = pos_x[AW-1:0];
    assign full    = (count_x == XW'(CAPACITY));
    assign item_x  = {32'd0, r_req.item};
    assign rd_x    = 64'(r_rd_q);

    always_comb begin
        chk = ST_OK;
        case (r_req.req_type)
            REQ_GET, REQ_SET, REQ_REMOVE: begin
                if (pos_x >= count_x) chk = ST_RANGE;
            end
            REQ_INSERT: begin
                if (pos_x > count_x) chk = ST_RANGE;
                else if (full)       chk = ST_FULL;
            end
            REQ_APPEND: begin
                if (full) chk = ST_FULL;
            end
            default: chk = ST_OK;
        endcase
    end

    // Memory port selection: one write and one registered read per cycle.
    always_comb begin
        we = 1'b0;
        wa = pos_a;
        wd = item_x[WORD_BITS-1:0];
        re = 1'b0;
        ra = pos_a;
        if (i_cmd.wr_idx) begin
            we = 1'b1;
        end
        if (i_cmd.finish && (r_req.req_type != REQ_REMOVE)) begin
            we = 1'b1;
        end
        if (i_cmd.shift_step && r_pend) begin
            we = 1'b1;
            wa = r_wa;
            wd = r_rd_q;
        end
        if (i_cmd.rd_idx) begin
            re = 1'b1;
        end
        if (i_cmd.shift_step && (r_left != '0)) begin
            re = 1'b1;
            ra = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (re) r_rd_q <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_req <= i_req;
        if (i_cmd.decide)  r_st  <= chk;
        if (i_cmd.emit) begin
            r_rsp.read_item <= ((r_req.req_type == REQ_GET) && (r_st == ST_OK)) ?
                               rd_x[31:0] : 32'd0;
            r_rsp.count_now <= count_x[8:0];
            r_rsp.status    <= r_st;
        end
        if (i_cmd.shift_up) begin
            r_ptr <= r_count[AW-1:0] - AW'(1);
            r_up  <= 1'b1;
        end else if (i_cmd.shift_dn) begin
            r_ptr <= pos_a + AW'(1);
            r_up  <= 1'b0;
        end else if (i_cmd.shift_step && (r_left != '0)) begin
            r_ptr <= r_up ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
            r_wa  <= r_up ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.shift_up) begin
                r_left <= CW'(count_x - pos_x);
                r_pend <= 1'b0;
            end else if (i_cmd.shift_dn) begin
                r_left <= CW'(count_x - pos_x - XW'(1));
                r_pend <= 1'b0;
            end else if (i_cmd.shift_step) begin
                r_pend <= (r_left != '0);
                if (r_left != '0) r_left <= r_left - CW'(1);
            end
            if (i_cmd.finish) begin
                if (r_req.req_type == REQ_REMOVE) r_count <= r_count - CW'(1);
                else                              r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.req        = r_req.req_type;
    assign o_sts.chk        = chk;
    assign o_sts.shift_busy = (r_left != '0) || r_pend;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- rtl/indexed_list_store.sv -----
// A get, a set, an unknown or a rejected request goes from acceptance through the decide and
// emit states to the output register. Insert, append and remove go through decide, shift,
// finish and emit; shift moves any entries with one memory read and one write per cycle.
// A result waiting in a stalled output register delays the next load. The input takes a new
// request in the cycle after each load, while that result may still wait to be taken.
// Synchronous active-low reset clears the count, the shift progress, the controller and the output valid only.
module indexed_list_store #(
    parameter int CAPACITY  = ils_pkg::ILS_CAPACITY,
    parameter int WORD_BITS = ils_pkg::ILS_WORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ils_pkg::t_in_req  i_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ils_pkg::t_out_rsp o_rsp
);
    import ils_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ils_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

endmodule
